/* rtl/core/bracket_depth_exact_counter_core_assert.svh */
// Assertion macros used by the checker file of the bracket depth counter.
`ifndef BRACKET_DEPTH_EXACT_COUNTER_CORE_ASSERT_SVH
`define BRACKET_DEPTH_EXACT_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BDEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdec assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdec assertion failed");

`endif

/* rtl/core/bdec_pkg.sv */
// Shared types, constants and helpers of the bracket depth counter.
`default_nettype none
package bdec_pkg;
   localparam int MaxPairs   = 32;
   localparam int TableDim   = MaxPairs + 1;
   localparam int TableDepth = TableDim * TableDim;
   localparam int AddrW      = $clog2(TableDepth);
   localparam int FieldW     = 6;
   localparam int CountW     = 56;
   localparam int HalfW      = CountW / 2;

   typedef logic [FieldW-1:0] field_type;
   typedef logic [CountW-1:0] count_type;
   typedef logic [AddrW-1:0]  addr_type;

   localparam count_type CountMax = 56'd55534064877048198;

   function automatic addr_type tbl_addr(input field_type row, input field_type col);
      addr_type base;
      base = AddrW'(row) * AddrW'(TableDim);
      return base + AddrW'(col);
   endfunction
endpackage
`default_nettype wire

/* rtl/core/bdec_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module bdec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/core/bracket_depth_exact_counter_core.sv */
// Top level of the exact-depth balanced bracket sequence counter.
// A query item on the req_ channel carries a pair count and a target depth; the
// rsp_ channel returns one item: the number of balanced sequences of that many
// pairs whose maximum nesting depth is exactly the target depth.
// After reset the block builds a table of counts of sequences with depth at most
// j in one synchronous RAM of 1089 entries, using one shared 28 by 28 bit
// multiplier. The build writes row 0 and column 0 in S_INIT_ROW and S_INIT_COL,
// then steps each product term through S_RA, S_RB and S_M0 to S_M4 and makes
// one write per entry in S_WR. req_stall is high for that whole time. The
// table is constant afterwards and is kept. A query is then a lookup: the
// result goes through S_OUT to the output register for out-of-range, zero-depth
// or too-deep queries, and through S_Q1, S_Q2, S_Q3 and S_OUT when two table
// entries are read and subtracted through the single read port. One query is
// worked on at a time; a new query is accepted while the previous result still
// waits in the output register. If rsp_stall holds that result, the next
// finished result waits in the block and req_stall stays high.
// Reset is synchronous and restarts the table build.
`default_nettype none
module bracket_depth_exact_counter_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire bdec_pkg::field_type req_pair_count,
   input  wire bdec_pkg::field_type req_target_depth,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output bdec_pkg::count_type      rsp_sequence_count
);
   import bdec_pkg::*;

   localparam logic [3:0] S_INIT_ROW = 4'd0;
   localparam logic [3:0] S_INIT_COL = 4'd1;
   localparam logic [3:0] S_RA       = 4'd2;
   localparam logic [3:0] S_RB       = 4'd3;
   localparam logic [3:0] S_M0       = 4'd4;
   localparam logic [3:0] S_M1       = 4'd5;
   localparam logic [3:0] S_M2       = 4'd6;
   localparam logic [3:0] S_M3       = 4'd7;
   localparam logic [3:0] S_M4       = 4'd8;
   localparam logic [3:0] S_WR       = 4'd9;
   localparam logic [3:0] S_IDLE     = 4'd10;
   localparam logic [3:0] S_Q1       = 4'd11;
   localparam logic [3:0] S_Q2       = 4'd12;
   localparam logic [3:0] S_Q3       = 4'd13;
   localparam logic [3:0] S_OUT      = 4'd14;

   localparam field_type LastIdx = FieldW'(MaxPairs);

   logic [3:0] state_ff, state_in;
   field_type  i_ff, i_in, j_ff, j_in, m_ff, m_in;
   field_type  pairs_ff, pairs_in, depth_ff, depth_in;
   count_type  acc_ff, acc_in, prod_ff, prod_in, opa_ff, opa_in, opb_ff, opb_in;
   count_type  rsp_count_ff, rsp_count_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       wr_en;
   addr_type   wr_addr, rd_addr;
   count_type  wr_data, rd_data;
   logic [HalfW-1:0] mul_x, mul_y;
   count_type  mul_p;

   bdec_ram #(.WIDTH(CountW), .DEPTH(TableDepth)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mul_p = mul_x * mul_y;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      m_in         = m_ff;
      pairs_in     = pairs_ff;
      depth_in     = depth_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = tbl_addr(i_ff, j_ff);
      wr_data      = acc_ff;
      rd_addr      = tbl_addr(m_ff, 6'(j_ff - 6'd1));
      mul_x        = opa_ff[HalfW-1:0];
      mul_y        = opb_ff[HalfW-1:0];

      unique case (state_ff)
         S_INIT_ROW: begin
            wr_en   = 1'b1;
            wr_addr = tbl_addr('0, j_ff);
            wr_data = count_type'(1);
            if (j_ff == LastIdx) begin
               i_in     = 6'd1;
               state_in = S_INIT_COL;
            end else begin
               j_in = 6'(j_ff + 6'd1);
            end
         end
         S_INIT_COL: begin
            wr_en   = 1'b1;
            wr_addr = tbl_addr(i_ff, '0);
            wr_data = '0;
            if (i_ff == LastIdx) begin
               i_in     = 6'd1;
               j_in     = 6'd1;
               m_in     = '0;
               acc_in   = '0;
               state_in = S_RA;
            end else begin
               i_in = 6'(i_ff + 6'd1);
            end
         end
         S_RA: begin
            state_in = S_RB;
         end
         S_RB: begin
            rd_addr  = tbl_addr(6'(i_ff - m_ff - 6'd1), j_ff);
            opa_in   = rd_data;
            state_in = S_M0;
         end
         S_M0: begin
            opb_in   = rd_data;
            state_in = S_M1;
         end
         S_M1: begin
            prod_in  = mul_p;
            state_in = S_M2;
         end
         S_M2: begin
            mul_y    = opb_ff[CountW-1:HalfW];
            acc_in   = acc_ff + prod_ff;
            prod_in  = {mul_p[HalfW-1:0], {HalfW{1'b0}}};
            state_in = S_M3;
         end
         S_M3: begin
            mul_x    = opa_ff[CountW-1:HalfW];
            acc_in   = acc_ff + prod_ff;
            prod_in  = {mul_p[HalfW-1:0], {HalfW{1'b0}}};
            state_in = S_M4;
         end
         S_M4: begin
            acc_in = acc_ff + prod_ff;
            if (m_ff == 6'(i_ff - 6'd1)) begin
               state_in = S_WR;
            end else begin
               m_in     = 6'(m_ff + 6'd1);
               state_in = S_RA;
            end
         end
         S_WR: begin
            wr_en  = 1'b1;
            acc_in = '0;
            m_in   = '0;
            if (j_ff == LastIdx) begin
               j_in = 6'd1;
               if (i_ff == LastIdx) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = 6'(i_ff + 6'd1);
                  state_in = S_RA;
               end
            end else begin
               j_in     = 6'(j_ff + 6'd1);
               state_in = S_RA;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               pairs_in = req_pair_count;
               depth_in = req_target_depth;
               priority if (req_pair_count > LastIdx) begin
                  acc_in   = '0;
                  state_in = S_OUT;
               end else if (req_target_depth == '0) begin
                  acc_in   = count_type'(req_pair_count == '0);
                  state_in = S_OUT;
               end else if (req_target_depth > req_pair_count) begin
                  acc_in   = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_Q1;
               end
            end
         end
         S_Q1: begin
            rd_addr  = tbl_addr(pairs_ff, depth_ff);
            state_in = S_Q2;
         end
         S_Q2: begin
            rd_addr  = tbl_addr(pairs_ff, 6'(depth_ff - 6'd1));
            opa_in   = rd_data;
            state_in = S_Q3;
         end
         S_Q3: begin
            acc_in   = opa_ff - rd_data;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_count_in = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT_ROW;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT_ROW;
         i_ff         <= '0;
         j_ff         <= '0;
         m_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         m_ff         <= m_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pairs_ff     <= pairs_in;
      depth_ff     <= depth_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sequence_count = rsp_count_ff;
endmodule
`default_nettype wire

/* rtl/core/bdec_checker.sv */
// Port-level checker of the bracket depth counter and its bind statement.
`default_nettype none
`include "bracket_depth_exact_counter_core_assert.svh"
module bdec_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire bdec_pkg::field_type req_pair_count,
   input wire bdec_pkg::field_type req_target_depth,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire bdec_pkg::count_type rsp_sequence_count
);
   import bdec_pkg::*;

   logic [1:0] open_ff, open_in;
   logic       req_acc, rsp_acc;
   logic       req_fields_known;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign req_fields_known = (req_pair_count == req_pair_count)
                          && (req_target_depth == req_target_depth);

   always_comb begin
      open_in = 2'(open_ff + 2'(req_acc) - 2'(rsp_acc));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   `BDEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sequence_count))
   `BDEC_ASSERT_NOW(a_rsp_has_query, clock, reset, rsp_valid, open_ff != 2'd0)
   `BDEC_ASSERT_NOW(a_one_in_work, clock, reset, req_acc && req_fields_known, open_ff <= 2'd1)
   `BDEC_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, rsp_sequence_count <= CountMax)
endmodule

bind bracket_depth_exact_counter_core bdec_checker u_bdec_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_pair_count     (req_pair_count),
   .req_target_depth   (req_target_depth),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_sequence_count (rsp_sequence_count)
);
`default_nettype wire

/* test/bracket_depth_exact_counter_core_tb.sv */
// Self-checking testbench of the exact-depth bracket sequence counter, with its own count table.
`timescale 1ns / 100ps
module bracket_depth_exact_counter_core_tb;
   import bdec_pkg::*;

   typedef struct {
      field_type pairs;
      field_type depth;
      bit        known;
      count_type count;
   } query_row_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   field_type req_pair_count;
   field_type req_target_depth;
   logic      rsp_valid;
   logic      rsp_stall;
   count_type rsp_sequence_count;

   count_type     depth_table [0:MaxPairs][0:MaxPairs];
   count_type     pending_counts[$];
   query_row_type directed_rows[$];
   int            mismatch_count = 0;
   int            burst_left = 0;

   bracket_depth_exact_counter_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pair_count     (req_pair_count),
      .req_target_depth   (req_target_depth),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sequence_count (rsp_sequence_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_200_000;
      $display("** bracket_depth_exact_counter_core: FAILED **");
      $finish;
   end

   function automatic void build_depth_table();
      logic [63:0] acc;
      for (int j = 0; j <= MaxPairs; j++) depth_table[0][j] = count_type'(1);
      for (int i = 1; i <= MaxPairs; i++) begin
         depth_table[i][0] = '0;
         for (int j = 1; j <= MaxPairs; j++) begin
            acc = '0;
            for (int m = 0; m < i; m++)
               acc = acc + 64'(depth_table[m][j-1]) * 64'(depth_table[i-m-1][j]);
            depth_table[i][j] = count_type'(acc);
         end
      end
   endfunction

   function automatic count_type predict_sequence_count(input field_type pairs,
                                                        input field_type depth);
      if (pairs > field_type'(MaxPairs)) return '0;
      if (depth == '0) return (pairs == '0) ? count_type'(1) : count_type'(0);
      if (depth > pairs) return '0;
      return depth_table[pairs][depth] - depth_table[pairs][depth - 1'b1];
   endfunction

   task automatic send_query(input field_type pairs, input field_type depth,
                             input bit known, input count_type count);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_pair_count   <= pairs;
      req_target_depth <= depth;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_counts.push_back(known ? count : predict_sequence_count(pairs, depth));
      @(negedge clock);
   endtask

   // The receiver switches at random among four stall patterns: none, random, and two periodic ones.
   initial begin
      int mode;
      int span;
      int phase;
      rsp_stall = 1'b0;
      mode = 0;
      span = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 80);
         end
         span--;
         phase++;
         case (mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_stall <= (phase % 5) != 0;
            end
            default: begin
               rsp_stall <= (phase % 24) < 12;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_counts.size() == 0) begin
            $error("unexpected item: sequence_count actual %0d", rsp_sequence_count);
            mismatch_count++;
         end else begin
            if (rsp_sequence_count !== pending_counts[0]) begin
               $error("sequence_count mismatch: expected %0d, actual %0d",
                      pending_counts[0], rsp_sequence_count);
               mismatch_count++;
            end
            void'(pending_counts.pop_front());
         end
      end
   end

   initial begin
      field_type pairs;
      field_type depth;
      int        top;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pair_count   = '0;
      req_target_depth = '0;
      build_depth_table();

      directed_rows.push_back(query_row_type'{6'd0,  6'd0,  1'b1, 56'd1});
      directed_rows.push_back(query_row_type'{6'd1,  6'd0,  1'b1, 56'd0});
      directed_rows.push_back(query_row_type'{6'd32, 6'd0,  1'b1, 56'd0});
      directed_rows.push_back(query_row_type'{6'd63, 6'd0,  1'b1, 56'd0});
      directed_rows.push_back(query_row_type'{6'd0,  6'd1,  1'b1, 56'd0});
      directed_rows.push_back(query_row_type'{6'd0,  6'd63, 1'b1, 56'd0});
      directed_rows.push_back(query_row_type'{6'd5,  6'd6,  1'b1, 56'd0});
      directed_rows.push_back(query_row_type'{6'd31, 6'd32, 1'b1, 56'd0});
      directed_rows.push_back(query_row_type'{6'd32, 6'd63, 1'b1, 56'd0});
      directed_rows.push_back(query_row_type'{6'd33, 6'd5,  1'b1, 56'd0});
      directed_rows.push_back(query_row_type'{6'd40, 6'd0,  1'b1, 56'd0});
      directed_rows.push_back(query_row_type'{6'd63, 6'd63, 1'b1, 56'd0});
      directed_rows.push_back(query_row_type'{6'd1,  6'd1,  1'b1, 56'd1});
      directed_rows.push_back(query_row_type'{6'd2,  6'd1,  1'b1, 56'd1});
      directed_rows.push_back(query_row_type'{6'd2,  6'd2,  1'b1, 56'd1});
      directed_rows.push_back(query_row_type'{6'd3,  6'd2,  1'b1, 56'd3});
      directed_rows.push_back(query_row_type'{6'd32, 6'd1,  1'b1, 56'd1});
      directed_rows.push_back(query_row_type'{6'd32, 6'd2,  1'b1, 56'd2147483647});
      directed_rows.push_back(query_row_type'{6'd32, 6'd32, 1'b1, 56'd1});
      directed_rows.push_back(query_row_type'{6'd32, 6'd31, 1'b0, 56'd0});
      directed_rows.push_back(query_row_type'{6'd32, 6'd16, 1'b0, 56'd0});
      directed_rows.push_back(query_row_type'{6'd32, 6'd5,  1'b0, 56'd0});
      directed_rows.push_back(query_row_type'{6'd20, 6'd10, 1'b0, 56'd0});
      directed_rows.push_back(query_row_type'{6'd10, 6'd3,  1'b0, 56'd0});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[k])
         send_query(directed_rows[k].pairs, directed_rows[k].depth,
                    directed_rows[k].known, directed_rows[k].count);

      // Mostly in-range queries near the interesting depths, plus raw 6-bit noise.
      for (int n = 0; n < 76; n++) begin
         if ($urandom_range(0, 4) != 0) begin
            pairs = field_type'($urandom_range(0, MaxPairs));
            top   = (int'(pairs) < MaxPairs) ? int'(pairs) + 1 : MaxPairs;
            depth = field_type'($urandom_range(0, top));
         end else begin
            pairs = field_type'($urandom_range(0, 63));
            depth = field_type'($urandom_range(0, 63));
         end
         send_query(pairs, depth, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_counts.size() == 0) begin
         $display("** bracket_depth_exact_counter_core: PASSED **");
      end else begin
         $display("** bracket_depth_exact_counter_core: FAILED **");
      end
      $finish;
   end
endmodule
